// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl of the polynomial hash accumulator
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_AT(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/phash_pkg.sv =====
// shared widths and constants of the polynomial hash accumulator
// no dependencies; used by the channel interfaces and the rtl modules
package phash_pkg;

   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 48;

   localparam logic [WORD_W-1:0] BASE_RESET = 64'd1000000000000037;

endpackage

// ===== hw/rtl/phash_if.sv =====
// valid/ready channel interfaces of the polynomial hash accumulator
// depends on phash_pkg for the payload widths
interface phash_req_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [phash_pkg::BYTE_W-1:0]    data_byte;
   logic [phash_pkg::WORD_W-1:0]    segment_hash;
   logic [phash_pkg::LEN_W-1:0]     segment_length;
   logic                            last;

   modport source (output valid, kind, data_byte, segment_hash, segment_length, last,
                   input ready);
   modport sink   (input valid, kind, data_byte, segment_hash, segment_length, last,
                   output ready);
endinterface

interface phash_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [phash_pkg::WORD_W-1:0]    hash_value;

   modport source (output valid, hash_value, input ready);
   modport sink   (input valid, hash_value, output ready);
endinterface

// ===== hw/rtl/phash_mul.sv =====
// 64 x 64 multiplier modulo 2^64 built on one 32 x 32 multiplier, one partial product at a time
// depends on phash_pkg; operands must stay stable from start until done
module phash_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [phash_pkg::WORD_W-1:0] op_a,
   input  logic [phash_pkg::WORD_W-1:0] op_b,
   output logic                         done,
   output logic [phash_pkg::WORD_W-1:0] product
);

   localparam int HW = phash_pkg::HALF_W;

   logic          run_ff, run_in;
   logic [1:0]    step_ff, step_in;
   logic          pval_ff, pval_in;
   logic [1:0]    pstep_ff, pstep_in;
   logic [2*HW-1:0] prod_ff, prod_in;
   logic [HW-1:0] lo_ff, lo_in;
   logic [HW-1:0] hi_ff, hi_in;
   logic          done_ff, done_in;
   logic [HW-1:0] mul_x;
   logic [HW-1:0] mul_y;

   // partial products: lo*lo, lo*hi, hi*lo; hi*hi falls outside 64 bits
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_x = op_a[HW-1:0];
            mul_y = op_b[HW-1:0];
         end
         2'd1: begin
            mul_x = op_a[HW-1:0];
            mul_y = op_b[2*HW-1:HW];
         end
         default: begin
            mul_x = op_a[2*HW-1:HW];
            mul_y = op_b[HW-1:0];
         end
      endcase
   end

   always_comb begin
      run_in   = run_ff;
      step_in  = step_ff;
      pval_in  = run_ff;
      pstep_in = step_ff;
      prod_in  = {{HW{1'b0}}, mul_x} * {{HW{1'b0}}, mul_y};
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      done_in  = 1'b0;
      if (start) begin
         run_in  = 1'b1;
         step_in = 2'd0;
      end else if (run_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd2) begin
            run_in = 1'b0;
         end
      end
      if (pval_ff) begin
         case (pstep_ff)
            2'd0: begin
               lo_in = prod_ff[HW-1:0];
               hi_in = prod_ff[2*HW-1:HW];
            end
            2'd1: begin
               hi_in = hi_ff + prod_ff[HW-1:0];
            end
            default: begin
               hi_in   = hi_ff + prod_ff[HW-1:0];
               done_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         pval_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 2'd0;
      end else begin
         run_ff  <= run_in;
         pval_ff <= pval_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      pstep_ff <= pstep_in;
      prod_ff  <= prod_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== hw/rtl/polynomial_hash_accumulator.sv =====
// channel   | dir | payload                                          | handshake
// req       | in  | kind, data_byte, segment_hash, segment_length, last | valid/ready
// rsp       | out | hash_value                                       | valid/ready
// csr       | in  | base (64 bits)                                   | csr_we only
//
// every 64-bit multiply runs on the shared 32 x 32 multiplier in phash_mul,
// issued through the start_ff register; the sequencer does one at a time
// byte item: 2 multiplies; segment item: 2 + popcount(len) +
// floor(log2(len)) multiplies (len saturated, just one for an empty segment)
// a last item also goes through S_EMIT to hand its hash to the output register,
// and stays there while that register still holds a hash that has not been taken
// req.ready stays low while an item is in work; synchronous reset, base back to default
// depends on phash_pkg, phash_if, phash_mul and assert_macros.svh
`include "assert_macros.svh"

module polynomial_hash_accumulator #(
   parameter int LENGTH_BITS = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   phash_req_if.sink                    req,
   phash_rsp_if.source                  rsp,
   input  logic                         csr_we,
   input  logic [phash_pkg::WORD_W-1:0] csr_wdata
);

   localparam int WW    = phash_pkg::WORD_W;
   localparam int LW    = phash_pkg::LEN_W;
   localparam int EXP_W = (LENGTH_BITS < LW) ? LENGTH_BITS : LW;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MAC   = 7'b0000010,
      S_PBASE = 7'b0000100,
      S_EMUL  = 7'b0001000,
      S_ESQ   = 7'b0010000,
      S_PFIN  = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [WW-1:0]     base_ff, base_in;
   logic [WW-1:0]     hash_ff, hash_in;
   logic [WW-1:0]     power_ff, power_in;
   logic [WW-1:0]     acc_ff, acc_in;
   logic [WW-1:0]     sq_ff, sq_in;
   logic [EXP_W-1:0]  exp_ff, exp_in;
   logic              kind_ff, kind_in;
   logic              last_ff, last_in;
   logic [WW-1:0]     op_a_ff, op_a_in;
   logic [WW-1:0]     op_b_ff, op_b_in;
   logic              start_ff, start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WW-1:0]     rsp_hash_ff, rsp_hash_in;

   logic              mul_done;
   logic [WW-1:0]     mul_product;
   logic [EXP_W-1:0]  sat_len;
   state_type         fin_state;
   logic              emit_load;

   phash_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .op_a    (op_a_ff),
      .op_b    (op_b_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   // lengths beyond the exponent width clamp to all ones
   generate
      if (EXP_W < LW) begin : g_sat
         assign sat_len = (|req.segment_length[LW-1:EXP_W]) ? {EXP_W{1'b1}}
                                                            : req.segment_length[EXP_W-1:0];
      end else begin : g_nosat
         assign sat_len = req.segment_length[EXP_W-1:0];
      end
   endgenerate

   assign req.ready      = (state_ff == S_IDLE);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hash_value = rsp_hash_ff;
   assign fin_state      = last_ff ? S_EMIT : S_IDLE;
   assign emit_load      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      state_in     = state_ff;
      base_in      = csr_we ? csr_wdata : base_ff;
      hash_in      = hash_ff;
      power_in     = power_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      exp_in       = exp_ff;
      kind_in      = kind_ff;
      last_in      = last_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_hash_in  = rsp_hash_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               kind_in  = req.kind;
               last_in  = req.last;
               exp_in   = sat_len;
               op_a_in  = req.kind ? req.segment_hash
                                   : {{(WW-phash_pkg::BYTE_W){1'b0}}, req.data_byte};
               op_b_in  = power_ff;
               start_in = 1'b1;
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            if (mul_done) begin
               hash_in = hash_ff + mul_product;
               if (!kind_ff) begin
                  op_a_in  = power_ff;
                  op_b_in  = base_ff;
                  start_in = 1'b1;
                  state_in = S_PBASE;
               end else begin
                  acc_in = {{(WW-1){1'b0}}, 1'b1};
                  sq_in  = base_ff;
                  if (exp_ff == '0) begin
                     state_in = fin_state;
                  end else if (exp_ff[0]) begin
                     op_a_in  = {{(WW-1){1'b0}}, 1'b1};
                     op_b_in  = base_ff;
                     start_in = 1'b1;
                     state_in = S_EMUL;
                  end else begin
                     op_a_in  = base_ff;
                     op_b_in  = base_ff;
                     start_in = 1'b1;
                     state_in = S_ESQ;
                  end
               end
            end
         end
         S_EMUL: begin
            if (mul_done) begin
               acc_in   = mul_product;
               start_in = 1'b1;
               // no higher exponent bits left: skip the final squaring
               if (exp_ff[EXP_W-1:1] == '0) begin
                  op_a_in  = power_ff;
                  op_b_in  = mul_product;
                  state_in = S_PFIN;
               end else begin
                  op_a_in  = sq_ff;
                  op_b_in  = sq_ff;
                  state_in = S_ESQ;
               end
            end
         end
         S_ESQ: begin
            if (mul_done) begin
               sq_in    = mul_product;
               exp_in   = exp_ff >> 1;
               start_in = 1'b1;
               if (exp_ff[1]) begin
                  op_a_in  = acc_ff;
                  op_b_in  = mul_product;
                  state_in = S_EMUL;
               end else begin
                  op_a_in  = mul_product;
                  op_b_in  = mul_product;
                  state_in = S_ESQ;
               end
            end
         end
         S_PBASE, S_PFIN: begin
            if (mul_done) begin
               power_in = mul_product;
               state_in = fin_state;
            end
         end
         S_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = hash_ff;
               hash_in      = '0;
               power_in     = {{(WW-1){1'b0}}, 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= phash_pkg::BASE_RESET;
         hash_ff      <= '0;
         power_ff     <= {{(WW-1){1'b0}}, 1'b1};
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         hash_ff      <= hash_in;
         power_ff     <= power_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      exp_ff      <= exp_in;
      kind_ff     <= kind_in;
      last_ff     <= last_in;
      op_a_ff     <= op_a_in;
      op_b_ff     <= op_b_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req.valid && req.ready, !req.ready)
   `ASSERT_NEXT(a_emit_restarts, clock, reset, emit_load, hash_ff == '0 && power_ff == 64'd1)
   `ASSERT_AT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT))
   `ASSERT_AT(a_done_when_busy, clock, reset, mul_done |-> state_ff != S_IDLE && state_ff != S_EMIT)

endmodule

// ===== sim/tb_polynomial_hash_accumulator.sv =====
// self-checking testbench of polynomial_hash_accumulator: random and directed items
// are checked against a cycle-free polynomial hash predictor, over several bases
// depends on phash_pkg, phash_if and the rtl of the block
`timescale 1ns / 100ps

module tb_polynomial_hash_accumulator;

   localparam int WORD_W           = phash_pkg::WORD_W;
   localparam int BYTE_W           = phash_pkg::BYTE_W;
   localparam int LEN_W            = phash_pkg::LEN_W;
   localparam int LENGTH_BITS      = 48;
   localparam int SETTLE_CYCLES    = 700;   // longest segment item plus the output stage
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int HOLD_AFTER_ITEMS = 400;
   localparam int PHASE_ITEMS      = 145;
   localparam int NUM_BASES        = 7;

   typedef enum logic {
      KIND_BYTE    = 1'b0,
      KIND_SEGMENT = 1'b1
   } item_kind_type;

   typedef struct packed {
      item_kind_type       kind;
      logic [BYTE_W-1:0]   data_byte;
      logic [WORD_W-1:0]   segment_hash;
      logic [LEN_W-1:0]    segment_length;
      logic                last;
   } hash_item_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [WORD_W-1:0] csr_wdata;

   phash_req_if req_bus ();
   phash_rsp_if rsp_bus ();

   polynomial_hash_accumulator #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [WORD_W-1:0] base_shadow = phash_pkg::BASE_RESET;
   logic [WORD_W-1:0] hash_sum    = '0;
   logic [WORD_W-1:0] pos_power   = 64'd1;

   hash_item_type     pending_items [$];
   logic [WORD_W-1:0] expected_hashes [$];
   hash_item_type     on_wire;

   int  send_pause = 0;
   int  recv_pause = 0;
   bit  send_calm  = 1'b0;
   bit  recv_calm  = 1'b0;
   logic rsp_hold;

   int items_accepted   = 0;
   int segments_seen    = 0;
   int results_checked  = 0;
   int mismatch_count   = 0;
   int settings_used    = 1;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [WORD_W-1:0] raise_base(input logic [WORD_W-1:0] b,
                                                    input logic [WORD_W-1:0] e);
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] sq;
      acc = 64'd1;
      sq  = b;
      for (int i = 0; i < WORD_W; i++) begin
         if (e[i]) acc = acc * sq;
         sq = sq * sq;
      end
      return acc;
   endfunction

   // fold one accepted item into the running hash
   task automatic absorb_item(input hash_item_type it);
      logic [WORD_W-1:0] len_cap;
      logic [WORD_W-1:0] len_sat;
      len_cap = {WORD_W{1'b1}} >> (WORD_W - LENGTH_BITS);
      len_sat = (64'(it.segment_length) > len_cap) ? len_cap : 64'(it.segment_length);
      items_accepted++;
      if (it.kind == KIND_BYTE) begin
         hash_sum  = hash_sum + 64'(it.data_byte) * pos_power;
         pos_power = pos_power * base_shadow;
      end else begin
         segments_seen++;
         hash_sum  = hash_sum + it.segment_hash * pos_power;
         pos_power = pos_power * raise_base(base_shadow, len_sat);
      end
      if (it.last) begin
         expected_hashes.insert(expected_hashes.size(), hash_sum);
         hash_sum  = '0;
         pos_power = 64'd1;
      end
   endtask

   function automatic int draw_pause(inout bit no_gaps);
      if ($urandom_range(0, 29) == 0) no_gaps = !no_gaps;
      return no_gaps ? 0 : $urandom_range(0, 10);
   endfunction

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                  input logic [WORD_W-1:0] want);
      mismatch_count++;
      $display("mismatch at %0t: %s, got %h expected %h", $time, what, got, want);
   endtask

   // item driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_pause    <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            absorb_item(on_wire);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_pause != 0) begin
               req_bus.valid <= 1'b0;
               send_pause    <= send_pause - 1;
            end else if (pending_items.size() != 0) begin
               on_wire = pending_items.pop_front();
               req_bus.kind           <= on_wire.kind;
               req_bus.data_byte      <= on_wire.data_byte;
               req_bus.segment_hash   <= on_wire.segment_hash;
               req_bus.segment_length <= on_wire.segment_length;
               req_bus.last           <= on_wire.last;
               req_bus.valid          <= 1'b1;
               send_pause             <= draw_pause(send_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      int                next_pause;
      logic [WORD_W-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_pause    <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_hashes.size() == 0) begin
               report_mismatch("hash with no item pending", rsp_bus.hash_value, '0);
            end else begin
               want = expected_hashes.pop_front();
               results_checked++;
               if (rsp_bus.hash_value !== want)
                  report_mismatch("hash_value", rsp_bus.hash_value, want);
            end
            next_pause     = draw_pause(recv_calm);
            recv_pause    <= next_pause;
            rsp_bus.ready <= (next_pause == 0) && !rsp_hold;
         end else if (recv_pause != 0) begin
            recv_pause    <= recv_pause - 1;
            rsp_bus.ready <= (recv_pause == 1) && !rsp_hold;
         end else begin
            rsp_bus.ready <= !rsp_hold;
         end
      end
   end

   // long hold-off on the result side so the block backs up into its input
   initial begin
      rsp_hold = 1'b0;
      wait (items_accepted >= HOLD_AFTER_ITEMS);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic queue_item(input item_kind_type kind, input logic [BYTE_W-1:0] data_byte,
                             input logic [WORD_W-1:0] seg_hash,
                             input logic [LEN_W-1:0] seg_len, input logic last);
      hash_item_type it;
      it.kind           = kind;
      it.data_byte      = data_byte;
      it.segment_hash   = seg_hash;
      it.segment_length = seg_len;
      it.last           = last;
      pending_items.insert(pending_items.size(), it);
   endtask

   // mostly short segments, a few of full random length or of the largest length
   function automatic logic [LEN_W-1:0] pick_length();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5)  return LEN_W'({$urandom, $urandom});
      if (sel < 8)  return '1;
      if (sel < 30) return LEN_W'($urandom_range(0, 1023));
      return LEN_W'($urandom_range(0, 16));
   endfunction

   function automatic logic [WORD_W-1:0] pick_hash();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0) return '0;
      if (sel == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   task automatic queue_stream(input int n_items);
      item_kind_type kind;
      for (int i = 0; i < n_items; i++) begin
         kind = ($urandom_range(0, 9) < 3) ? KIND_SEGMENT : KIND_BYTE;
         queue_item(kind, BYTE_W'($urandom_range(0, 255)), pick_hash(), pick_length(),
                    i == n_items - 1);
      end
   endtask

   task automatic queue_random_phase(input int target);
      int count;
      int n;
      count = 0;
      while (count < target) begin
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
         queue_stream(n);
         count += n;
      end
   endtask

   // sender pause: everything accepted, every hash back, block quiet
   task automatic wait_drained();
      while (pending_items.size() != 0 || req_bus.valid || expected_hashes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [WORD_W-1:0] base_plan [0:NUM_BASES-1];
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_wdata              = '0;
      req_bus.valid          = 1'b0;
      req_bus.kind           = 1'b0;
      req_bus.data_byte      = '0;
      req_bus.segment_hash   = '0;
      req_bus.segment_length = '0;
      req_bus.last           = 1'b0;
      rsp_bus.ready          = 1'b0;
      base_plan[0] = '0;
      base_plan[1] = 64'd1;
      base_plan[2] = '1;
      base_plan[3] = 64'h8000_0000_0000_0000;
      base_plan[4] = {$urandom, $urandom};
      base_plan[5] = 64'd2;
      base_plan[6] = phash_pkg::BASE_RESET;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed items under the reset base
      queue_item(KIND_BYTE,    8'h00, '1, '1, 1'b0);     // unused fields all ones
      queue_item(KIND_BYTE,    8'hFF, '0, '0, 1'b1);
      queue_item(KIND_BYTE,    8'h80, '0, '0, 1'b1);     // one-item stream
      queue_item(KIND_SEGMENT, 8'hFF, '1, '0, 1'b0);     // empty segment
      queue_item(KIND_BYTE,    8'h01, '0, '0, 1'b1);
      queue_item(KIND_SEGMENT, 8'h00, '0, '1, 1'b0);     // longest segment
      queue_item(KIND_BYTE,    8'h7F, '1, '1, 1'b1);
      queue_item(KIND_SEGMENT, 8'h55, 64'h8000_0000_0000_0000, 48'd1, 1'b1);
      queue_item(KIND_SEGMENT, 8'hAA, 64'h0123_4567_89AB_CDEF, 48'h8000_0000_0000, 1'b0);
      queue_item(KIND_SEGMENT, 8'h00, '1, 48'h5555_5555_5555, 1'b0);
      queue_item(KIND_BYTE,    8'hA5, '0, '0, 1'b1);
      queue_item(KIND_BYTE,    8'h01, '1, '0, 1'b0);
      queue_item(KIND_BYTE,    8'h02, '0, '1, 1'b0);
      queue_item(KIND_BYTE,    8'h03, '0, '0, 1'b0);
      queue_item(KIND_SEGMENT, 8'h00, '1, 48'd3, 1'b1);
      queue_item(KIND_SEGMENT, 8'hFF, 64'd1, 48'hAAAA_AAAA_AAAA, 1'b1);
      queue_item(KIND_SEGMENT, 8'h00, '0, '0, 1'b1);     // empty stream, zero hash
      queue_random_phase(PHASE_ITEMS);

      for (int p = 0; p < NUM_BASES; p++) begin
         wait_drained();
         @(posedge clock);
         csr_we      <= 1'b1;
         csr_wdata   <= base_plan[p];
         base_shadow <= base_plan[p];
         @(posedge clock);
         csr_we <= 1'b0;
         settings_used++;
         @(negedge clock);
         queue_random_phase(PHASE_ITEMS);
      end

      wait_drained();
      $display("%0d items accepted (%0d segments) under %0d base settings",
               items_accepted, segments_seen, settings_used);
      $display("%0d hashes checked, %0d mismatches", results_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_polynomial_hash_accumulator OK");
      else
         $display("tb_polynomial_hash_accumulator NOT OK");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("timeout with %0d hashes still pending", expected_hashes.size());
      $display("tb_polynomial_hash_accumulator NOT OK");
      $finish;
   end

endmodule
